@@ rtl/tlvrs_pkg.sv @@
// ---------------------------------------------------------------------------
// tlvrs_pkg
// Types and constants shared by the record search block and its interfaces.
// ---------------------------------------------------------------------------
package tlvrs_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_PTR_W = 2;
	localparam int unsigned Q_CNT_W = 3;

	localparam logic [BYTE_W-1:0] END_TYPE = 8'hff;
	localparam logic [BYTE_W-1:0] MIN_LEN  = 8'd2;

	localparam logic [0:0] REG_WANTED_TYPE  = 1'b0;
	localparam logic [0:0] REG_MAX_COPY_LEN = 1'b1;

	localparam logic RES_PAYLOAD = 1'b0;
	localparam logic RES_STATUS  = 1'b1;

	typedef enum logic [4:0] {
		PH_MAGIC = 5'b00001,
		PH_TYPE  = 5'b00010,
		PH_LEN   = 5'b00100,
		PH_BODY  = 5'b01000,
		PH_DEAD  = 5'b10000
	} phase_t;

	typedef struct packed {
		logic              result_kind;
		logic [BYTE_W-1:0] payload_byte;
		logic [BYTE_W-1:0] payload_index;
		logic              found;
		logic [BYTE_W-1:0] value_length;
		logic              run_last;
	} result_t;

	function automatic logic [BYTE_W-1:0] magic_byte(input logic [1:0] idx);
		logic [BYTE_W-1:0] b;
		case (idx)
			2'd0:    b = 8'h56;
			2'd1:    b = 8'h12;
			2'd2:    b = 8'h09;
			default: b = 8'h85;
		endcase
		return b;
	endfunction

endpackage

@@ rtl/tlvrs_if.sv @@
// ---------------------------------------------------------------------------
// tlvrs_if
// Valid/ready channels for store bytes in and search results out.
// ---------------------------------------------------------------------------
interface tlvrs_store_if import tlvrs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] store_byte;
	logic              sector_first;
	logic              scan_last;

	modport source (output valid, output store_byte, output sector_first,
		output scan_last, input ready);
	modport sink (input valid, input store_byte, input sector_first,
		input scan_last, output ready);
endinterface

interface tlvrs_result_if import tlvrs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              result_kind;
	logic [BYTE_W-1:0] payload_byte;
	logic [BYTE_W-1:0] payload_index;
	logic              found;
	logic [BYTE_W-1:0] value_length;
	logic              run_last;

	modport source (output valid, output result_kind, output payload_byte,
		output payload_index, output found, output value_length,
		output run_last, input ready);
	modport sink (input valid, input result_kind, input payload_byte,
		input payload_index, input found, input value_length,
		input run_last, output ready);
endinterface

@@ rtl/tlv_setting_record_search_top.sv @@
// ---------------------------------------------------------------------------
// tlv_setting_record_search_top
// Walks a settings store byte by byte, checks sector magic headers, parses
// type/length records and passes out the payload of the wanted record type
// together with a final found/length status.
//
//   channel     dir   handshake      payload
//   store_ch    in    valid/ready    store_byte, sector_first, scan_last
//   result_ch   out   valid/ready    result_kind, payload_byte, payload_index,
//                                    found, value_length, run_last
//   cfg         in    cfg_we         cfg_index, cfg_data
//
// Each byte is parsed in the cycle it is taken; its results (up to two)
// land in a four-entry result queue, drained one per cycle while result_ch.ready is high.
// A byte is taken whenever the queue has room for two results, so one byte
// per cycle is sustained while the result side keeps draining the queue.
// Reset is asynchronous and clears all parse state and the queue at once.
// A stalled result side fills the queue and then holds off store bytes.
// ---------------------------------------------------------------------------
module tlv_setting_record_search_top
	import tlvrs_pkg::*;
#(
	parameter int unsigned SECTOR_BYTES = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	tlvrs_store_if.sink       store_ch,
	tlvrs_result_if.source    result_ch,
	input  logic              cfg_we,
	input  logic [0:0]        cfg_index,
	input  logic [BYTE_W-1:0] cfg_data
);

	localparam int unsigned OFF_W = $clog2(SECTOR_BYTES + 1);
	localparam logic [OFF_W-1:0] OFF_END = OFF_W'(SECTOR_BYTES);

	logic [BYTE_W-1:0] wanted_type_q;
	logic [BYTE_W-1:0] max_copy_len_q;

	phase_t            phase_q;
	logic [OFF_W-1:0]  offset_q;
	logic              magic_ok_q;
	logic [BYTE_W-1:0] bytes_left_q;
	logic              matches_q;
	logic [BYTE_W-1:0] copy_index_q;
	logic              any_found_q;
	logic [BYTE_W-1:0] last_length_q;

	phase_t            phase_d;
	logic [OFF_W-1:0]  offset_d;
	logic              magic_ok_d;
	logic [BYTE_W-1:0] bytes_left_d;
	logic              matches_d;
	logic [BYTE_W-1:0] copy_index_d;
	logic              any_found_d;
	logic [BYTE_W-1:0] last_length_d;

	logic              emit_pay;
	logic [BYTE_W-1:0] pay_index;
	logic              emit_stat;
	logic              stat_found;
	logic [BYTE_W-1:0] stat_length;

	result_t           res0;
	result_t           res1;
	logic [1:0]        n_res;

	result_t           queue_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	logic              take;
	logic              give;
	result_t           head;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wanted_type_q  <= 8'd1;
			max_copy_len_q <= 8'd7;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WANTED_TYPE:  wanted_type_q  <= cfg_data;
				REG_MAX_COPY_LEN: max_copy_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign store_ch.ready = (count_q <= Q_CNT_W'(Q_DEPTH - 2));
	assign take = store_ch.valid && store_ch.ready;

	// parse step for one byte
	always_comb begin
		phase_d       = phase_q;
		offset_d      = offset_q;
		magic_ok_d    = magic_ok_q;
		bytes_left_d  = bytes_left_q;
		matches_d     = matches_q;
		copy_index_d  = copy_index_q;
		any_found_d   = any_found_q;
		last_length_d = last_length_q;
		emit_pay      = 1'b0;
		pay_index     = copy_index_q;
		emit_stat     = 1'b0;
		stat_found    = 1'b0;
		stat_length   = '0;

		if (store_ch.sector_first) begin
			phase_d      = PH_MAGIC;
			offset_d     = '0;
			magic_ok_d   = 1'b1;
			bytes_left_d = '0;
			matches_d    = 1'b0;
		end
		if (offset_d == OFF_END) begin
			phase_d = PH_DEAD;
		end

		case (phase_d)
			PH_MAGIC: begin
				if (store_ch.store_byte != magic_byte(offset_d[1:0])) begin
					magic_ok_d = 1'b0;
				end
				if (offset_d >= OFF_W'(3)) begin
					phase_d = magic_ok_d ? PH_TYPE : PH_DEAD;
				end
			end
			PH_TYPE: begin
				if (store_ch.store_byte == END_TYPE) begin
					phase_d = PH_DEAD;
				end else begin
					matches_d = (store_ch.store_byte == wanted_type_q);
					phase_d   = PH_LEN;
				end
			end
			PH_LEN: begin
				if (store_ch.store_byte < MIN_LEN) begin
					phase_d   = PH_DEAD;
					matches_d = 1'b0;
				end else begin
					bytes_left_d = store_ch.store_byte - MIN_LEN;
					copy_index_d = '0;
					if (matches_d) begin
						any_found_d   = 1'b1;
						last_length_d = bytes_left_d;
					end
					phase_d = (bytes_left_d == '0) ? PH_TYPE : PH_BODY;
				end
			end
			PH_BODY: begin
				if (matches_d && (copy_index_d < max_copy_len_q)) begin
					emit_pay     = 1'b1;
					pay_index    = copy_index_d;
					copy_index_d = copy_index_d + 8'd1;
				end
				if (bytes_left_d != '0) begin
					bytes_left_d = bytes_left_d - 8'd1;
				end
				if (bytes_left_d == '0) begin
					phase_d = PH_TYPE;
				end
			end
			default: begin
				phase_d = PH_DEAD;
			end
		endcase

		if (offset_d != OFF_END) begin
			offset_d = offset_d + OFF_W'(1);
		end

		if (store_ch.scan_last) begin
			emit_stat     = 1'b1;
			stat_found    = any_found_d;
			stat_length   = any_found_d ? last_length_d : '0;
			phase_d       = PH_MAGIC;
			offset_d      = '0;
			magic_ok_d    = 1'b1;
			bytes_left_d  = '0;
			matches_d     = 1'b0;
			copy_index_d  = '0;
			any_found_d   = 1'b0;
			last_length_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_MAGIC;
			offset_q      <= '0;
			magic_ok_q    <= 1'b1;
			bytes_left_q  <= '0;
			matches_q     <= 1'b0;
			copy_index_q  <= '0;
			any_found_q   <= 1'b0;
			last_length_q <= '0;
		end else if (take) begin
			phase_q       <= phase_d;
			offset_q      <= offset_d;
			magic_ok_q    <= magic_ok_d;
			bytes_left_q  <= bytes_left_d;
			matches_q     <= matches_d;
			copy_index_q  <= copy_index_d;
			any_found_q   <= any_found_d;
			last_length_q <= last_length_d;
		end
	end

	// results of this byte, payload first
	always_comb begin
		res0.result_kind   = RES_PAYLOAD;
		res0.payload_byte  = store_ch.store_byte;
		res0.payload_index = pay_index;
		res0.found         = 1'b0;
		res0.value_length  = '0;
		res0.run_last      = !emit_stat;

		res1.result_kind   = RES_STATUS;
		res1.payload_byte  = '0;
		res1.payload_index = '0;
		res1.found         = stat_found;
		res1.value_length  = stat_length;
		res1.run_last      = 1'b1;

		n_res = {1'b0, emit_pay} + {1'b0, emit_stat};
	end

	// result queue
	assign head             = queue_q[rd_ptr_q];
	assign give             = result_ch.valid && result_ch.ready;
	assign result_ch.valid  = (count_q != '0);
	assign result_ch.result_kind   = head.result_kind;
	assign result_ch.payload_byte  = head.payload_byte;
	assign result_ch.payload_index = head.payload_index;
	assign result_ch.found         = head.found;
	assign result_ch.value_length  = head.value_length;
	assign result_ch.run_last      = head.run_last;

	always_ff @(posedge clk) begin
		if (take) begin
			if (emit_pay) begin
				queue_q[wr_ptr_q] <= res0;
				if (emit_stat) begin
					queue_q[wr_ptr_q + Q_PTR_W'(1)] <= res1;
				end
			end else if (emit_stat) begin
				queue_q[wr_ptr_q] <= res1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (take) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(n_res);
			end
			if (give) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			count_q <= count_q + (take ? Q_CNT_W'(n_res) : '0)
				- (give ? Q_CNT_W'(1) : '0);
		end
	end

`ifndef SYNTHESIS
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= Q_CNT_W'(Q_DEPTH))
		else $error("result queue overflow");

	a_scan_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(take && store_ch.scan_last) |=> (!any_found_q && phase_q == PH_MAGIC
		&& offset_q == '0))
		else $error("state not cleared after final byte");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(!take && give) |=> (count_q == $past(count_q) - Q_CNT_W'(1)))
		else $error("queue count lost an item");

	a_payload_in_body: assert property (@(posedge clk) disable iff (!arst_n)
		(take && emit_pay && !store_ch.scan_last)
		|-> (copy_index_d == pay_index + 8'd1))
		else $error("copy index not advanced with payload");
`endif

endmodule
